// File: rtl/core/stq_pkg.sv
// Shared types and codes for the sorted timer task queue.
package stq_pkg;

  localparam logic [1:0] KIND_POST   = 2'd0;
  localparam logic [1:0] KIND_SCHED  = 2'd1;
  localparam logic [1:0] KIND_POLL   = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  localparam logic [2:0] STAT_FIRED    = 3'd0;
  localparam logic [2:0] STAT_ACCEPTED = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_CANCEL   = 3'd3;
  localparam logic [2:0] STAT_NONE     = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [63:0] time_now;
    logic [31:0] delay_ticks;
  } stq_req_t;

  typedef struct packed {
    logic [7:0] fired_id;
    logic [2:0] status;
    logic       last;
  } stq_res_t;

  // One timer entry without its id (id width is a top-level parameter).
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [63:0] due;
    logic [31:0] per;
  } stq_ent_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_POPINS,
    OP_HIT,
    OP_KILL,
    OP_PACK
  } stq_op_t;

  // Broadcast command to every cell of the row.
  typedef struct packed {
    stq_op_t     op;
    logic [63:0] key;
    logic [31:0] per;
  } stq_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIRE,
    S_PACK
  } stq_state_t;

endpackage

// File: rtl/core/stq_cell.sv
// One slot of the sorted timer row: holds an entry and trades it with its neighbors.
module stq_cell #(
  parameter int ID_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  stq_pkg::stq_cmd_t   cmd,
  input  logic [ID_BITS-1:0]  cmd_id,
  input  stq_pkg::stq_ent_t   hi,
  input  logic [ID_BITS-1:0]  hi_id,
  input  stq_pkg::stq_ent_t   lo_view,
  input  logic [ID_BITS-1:0]  lo_view_id,
  input  logic                lo_le,
  input  logic                lo_valid,
  output stq_pkg::stq_ent_t   ent,
  output logic [ID_BITS-1:0]  ent_id,
  output stq_pkg::stq_ent_t   view,
  output logic [ID_BITS-1:0]  view_id,
  output logic                le
);

  stq_pkg::stq_ent_t  ent_next;
  logic [ID_BITS-1:0] id_next;
  stq_pkg::stq_ent_t  fresh;
  logic               pop;

  // A pop shifts the row down before any compare or insert.
  assign pop     = (cmd.op == stq_pkg::OP_POP) || (cmd.op == stq_pkg::OP_POPINS);
  assign view    = pop ? hi : ent;
  assign view_id = pop ? hi_id : ent_id;
  assign le      = view.valid && (view.due <= cmd.key);

  always_comb begin
    fresh.valid = 1'b1;
    fresh.hit   = 1'b0;
    fresh.due   = cmd.key;
    fresh.per   = cmd.per;
  end

  always_comb begin
    ent_next = ent;
    id_next  = ent_id;
    case (cmd.op)
      stq_pkg::OP_HOLD: begin
        ent_next = ent;
      end
      stq_pkg::OP_INSERT, stq_pkg::OP_POPINS: begin
        // Stay behind every entry due no later than the new one.
        if (le) begin
          ent_next = view;
          id_next  = view_id;
        end else if (lo_le) begin
          ent_next = fresh;
          id_next  = cmd_id;
        end else begin
          ent_next = lo_view;
          id_next  = lo_view_id;
        end
      end
      stq_pkg::OP_POP: begin
        ent_next = view;
        id_next  = view_id;
      end
      stq_pkg::OP_HIT: begin
        ent_next.hit = le;
      end
      stq_pkg::OP_KILL: begin
        ent_next.valid = ent.valid && (ent_id != cmd_id);
      end
      stq_pkg::OP_PACK: begin
        // Move a hole up by one slot per cycle.
        if (!ent.valid && hi.valid) begin
          ent_next = hi;
          id_next  = hi_id;
        end else if (ent.valid && !lo_valid) begin
          ent_next.valid = 1'b0;
        end
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      ent.hit   <= 1'b0;
    end else begin
      ent    <= ent_next;
      ent_id <= id_next;
    end
  end

endmodule

// File: rtl/core/sorted_timer_task_queue_top.sv
// Top level of the sorted timer task queue: command sequencer and row of cells.
//
// Usage: drive req and raise start; the beat is taken at a clock edge where
// start is high and busy is low. Each result beat shows on res for one cycle
// with strobe high and must be taken then; the receiver cannot stall it.
// Post and schedule give one beat (accepted or table full). Cancel marks
// matching entries, then closes the gaps one slot per cycle, and gives its
// single beat once no gap is left. Poll marks due entries, then fires one
// entry per cycle (pop and periodic reload happen together across the row),
// or gives a single "nothing due" beat when no entry is due. The row has
// DEPTH cells; every cell compares its due tick against a broadcast key in
// the same cycle. res.last marks the final beat of a command; busy stays
// high until the command's last beat has been produced. Reset empties the
// table at once.
module sorted_timer_task_queue_top #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  stq_pkg::stq_req_t req,
  output logic              strobe,
  output stq_pkg::stq_res_t res
);

  stq_pkg::stq_state_t state;
  stq_pkg::stq_state_t state_next;
  stq_pkg::stq_req_t   req_q;
  logic [63:0]         key;
  logic [63:0]         key_next;
  stq_pkg::stq_cmd_t   cmd;
  logic [ID_BITS-1:0]  cmd_id;
  stq_pkg::stq_res_t   res_next;
  logic                strobe_next;

  stq_pkg::stq_ent_t   ent     [DEPTH];
  logic [ID_BITS-1:0]  ent_id  [DEPTH];
  stq_pkg::stq_ent_t   view    [DEPTH];
  logic [ID_BITS-1:0]  view_id [DEPTH];
  logic [DEPTH-1:0]    le;
  logic [DEPTH-1:0]    vbits;
  logic [DEPTH-2:0]    holes;
  logic [64:0]         in_sum;
  logic [64:0]         reload_sum;
  logic [63:0]         reload_tick;

  // Row of cells: each sees its upper neighbor's entry and lower neighbor's view.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    stq_pkg::stq_ent_t  hi_e;
    logic [ID_BITS-1:0] hi_i;
    stq_pkg::stq_ent_t  lo_e;
    logic [ID_BITS-1:0] lo_i;
    logic               lo_l;
    logic               lo_v;

    if (i == DEPTH - 1) begin : g_top
      assign hi_e = '0;
      assign hi_i = '0;
    end else begin : g_mid
      assign hi_e = ent[i+1];
      assign hi_i = ent_id[i+1];
    end

    if (i == 0) begin : g_first
      assign lo_e = '0;
      assign lo_i = '0;
      assign lo_l = 1'b1;
      assign lo_v = 1'b1;
    end else begin : g_rest
      assign lo_e = view[i-1];
      assign lo_i = view_id[i-1];
      assign lo_l = le[i-1];
      assign lo_v = ent[i-1].valid;
    end

    stq_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .cmd_id    (cmd_id),
      .hi        (hi_e),
      .hi_id     (hi_i),
      .lo_view   (lo_e),
      .lo_view_id(lo_i),
      .lo_le     (lo_l),
      .lo_valid  (lo_v),
      .ent       (ent[i]),
      .ent_id    (ent_id[i]),
      .view      (view[i]),
      .view_id   (view_id[i]),
      .le        (le[i])
    );

    assign vbits[i] = ent[i].valid;
  end

  assign holes = ~vbits[DEPTH-2:0] & vbits[DEPTH-1:1];
  assign busy  = (state != stq_pkg::S_IDLE);

  // Saturating tick sums.
  assign in_sum      = {1'b0, req.time_now} + {33'd0, req.delay_ticks};
  assign reload_sum  = {1'b0, req_q.time_now} + {33'd0, ent[0].per};
  assign reload_tick = reload_sum[64] ? '1 : reload_sum[63:0];

  always_comb begin
    key_next = key;
    case (req.kind)
      stq_pkg::KIND_POST: begin
        if (req.delay_ticks == 32'd0) key_next = 64'd0;
        else key_next = in_sum[64] ? '1 : in_sum[63:0];
      end
      stq_pkg::KIND_SCHED: key_next = in_sum[64] ? '1 : in_sum[63:0];
      stq_pkg::KIND_POLL:  key_next = req.time_now;
      default:             key_next = key;
    endcase
  end

  always_comb begin
    state_next        = state;
    cmd.op            = stq_pkg::OP_HOLD;
    cmd.key           = key;
    cmd.per           = 32'd0;
    cmd_id            = ID_BITS'(req_q.task_id);
    strobe_next       = 1'b0;
    res_next.fired_id = 8'd0;
    res_next.status   = stq_pkg::STAT_NONE;
    res_next.last     = 1'b1;
    case (state)
      stq_pkg::S_IDLE: begin
        if (start) state_next = stq_pkg::S_RUN;
      end
      stq_pkg::S_RUN: begin
        case (req_q.kind)
          stq_pkg::KIND_POST, stq_pkg::KIND_SCHED: begin
            strobe_next = 1'b1;
            state_next  = stq_pkg::S_IDLE;
            if (vbits[DEPTH-1]) begin
              res_next.status = stq_pkg::STAT_FULL;
            end else begin
              res_next.status = stq_pkg::STAT_ACCEPTED;
              cmd.op          = stq_pkg::OP_INSERT;
              if (req_q.kind == stq_pkg::KIND_SCHED) cmd.per = req_q.delay_ticks;
            end
          end
          stq_pkg::KIND_POLL: begin
            cmd.op     = stq_pkg::OP_HIT;
            state_next = stq_pkg::S_FIRE;
          end
          default: begin
            cmd.op     = stq_pkg::OP_KILL;
            state_next = stq_pkg::S_PACK;
          end
        endcase
      end
      stq_pkg::S_FIRE: begin
        strobe_next = 1'b1;
        if (ent[0].valid && ent[0].hit) begin
          res_next.fired_id = 8'(ent_id[0]);
          res_next.status   = stq_pkg::STAT_FIRED;
          res_next.last     = !(ent[1].valid && ent[1].hit);
          cmd_id            = ent_id[0];
          // Reload a periodic entry behind everything due now.
          if (ent[0].per != 32'd0) begin
            cmd.op  = stq_pkg::OP_POPINS;
            cmd.key = reload_tick;
            cmd.per = ent[0].per;
          end else begin
            cmd.op = stq_pkg::OP_POP;
          end
          if (!(ent[1].valid && ent[1].hit)) state_next = stq_pkg::S_IDLE;
        end else begin
          res_next.status = stq_pkg::STAT_NONE;
          state_next      = stq_pkg::S_IDLE;
        end
      end
      stq_pkg::S_PACK: begin
        cmd.op = stq_pkg::OP_PACK;
        if (holes == '0) begin
          strobe_next     = 1'b1;
          res_next.status = stq_pkg::STAT_CANCEL;
          state_next      = stq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= stq_pkg::S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (start && !busy) begin
      req_q <= req;
      key   <= key_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == stq_pkg::S_IDLE) |-> (holes == '0))
    else $error("valid entries do not form a prefix while idle");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && res.status != stq_pkg::STAT_FIRED) |-> (res.fired_id == 8'd0))
    else $error("fired_id set on a beat that is not a fire");

  a_multi_fire: assert property (@(posedge clk) disable iff (rst)
    (strobe && !res.last) |-> (res.status == stq_pkg::STAT_FIRED))
    else $error("non-final beat that is not a fire");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && res.last) |=> !strobe)
    else $error("beat follows the final beat of a command");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !strobe))
    else $error("accepted command did not start a sequence");
`endif

endmodule
